[hdl/ftl_pkg.sv]
// ftl_pkg: shared types and codes for the form text lexer
// lexer states, token classes, result kinds and character codes; no dependencies
`timescale 1ns / 1ps

package ftl_pkg;

    // lexer state
    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_SYM    = 4'd1,
        ST_HEX    = 4'd2,
        ST_INT    = 4'd3,
        ST_FLT    = 4'd4,
        ST_CODE   = 4'd5,
        ST_QUOTE  = 4'd6,
        ST_AFTERQ = 4'd7
    } t_lex_state;

    // token class
    typedef enum logic [2:0] {
        CL_SYM  = 3'd0,
        CL_STR  = 3'd1,
        CL_INT  = 3'd2,
        CL_FLT  = 3'd3,
        CL_CHAR = 3'd4,
        CL_END  = 3'd5
    } t_tok_class;

    // result kind
    typedef enum logic [1:0] {
        KD_TOKEN = 2'd0,
        KD_CHAR  = 2'd1,
        KD_ERROR = 2'd2
    } t_res_kind;

    // control part of one result
    typedef struct packed {
        t_res_kind  kind;
        t_tok_class cls;
    } t_res_ctl;

    // results one character can cause, and the index/count and token length widths
    localparam int RES_MAX   = 3;
    localparam int IDX_WIDTH = 2;
    localparam int LEN_WIDTH = 16;

    // character codes
    localparam logic [31:0] C_NUL      = 32'd0;
    localparam logic [31:0] C_LF       = 32'd10;
    localparam logic [31:0] C_CR       = 32'd13;
    localparam logic [31:0] C_FIRST_VIS = 32'd33;
    localparam logic [31:0] C_LAST_VIS = 32'd255;
    localparam logic [31:0] C_HASH     = 32'd35;
    localparam logic [31:0] C_DOLLAR   = 32'd36;
    localparam logic [31:0] C_QUOTE    = 32'd39;
    localparam logic [31:0] C_PLUS     = 32'd43;
    localparam logic [31:0] C_MINUS    = 32'd45;
    localparam logic [31:0] C_DOT      = 32'd46;
    localparam logic [31:0] C_ZERO     = 32'd48;
    localparam logic [31:0] C_NINE     = 32'd57;
    localparam logic [31:0] C_COLON    = 32'd58;
    localparam logic [31:0] C_UP_A     = 32'd65;
    localparam logic [31:0] C_UP_F     = 32'd70;
    localparam logic [31:0] C_UP_Z     = 32'd90;
    localparam logic [31:0] C_UNDER    = 32'd95;
    localparam logic [31:0] C_LO_A     = 32'd97;
    localparam logic [31:0] C_LO_E     = 32'd101;
    localparam logic [31:0] C_LO_F     = 32'd102;
    localparam logic [31:0] C_LO_Z     = 32'd122;

endpackage

[hdl/ftl_in_reg.sv]
// ftl_in_reg: input register for the character stream
// holds one character until the lexer core takes it; uses ftl_pkg only for style
`timescale 1ns / 1ps

module ftl_in_reg
    import ftl_pkg::*;
#(
    parameter int CHAR_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CHAR_WIDTH-1:0] i_ch,
    output logic                  o_valid,
    output logic [CHAR_WIDTH-1:0] o_ch,
    input  logic                  i_take
);

    logic                  r_valid;
    logic [CHAR_WIDTH-1:0] r_ch;

    // stall only while the held character is not taken this cycle
    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_ch    = r_ch;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // character payload
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_ch <= i_ch;
        end
    end

endmodule

[hdl/ftl_core.sv]
// ftl_core: per-character lexer state update and result building
// one character per take; produces up to RES_MAX results; uses ftl_pkg
`timescale 1ns / 1ps

module ftl_core
    import ftl_pkg::*;
#(
    parameter int POS_WIDTH  = 32,
    parameter int CHAR_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [CHAR_WIDTH-1:0] i_ch,
    output logic [IDX_WIDTH-1:0]  o_cnt,
    output t_res_ctl              o_ctl   [RES_MAX],
    output logic [CHAR_WIDTH-1:0] o_val   [RES_MAX],
    output logic [POS_WIDTH-1:0]  o_start [RES_MAX],
    output logic [LEN_WIDTH-1:0]  o_len   [RES_MAX],
    output logic [POS_WIDTH-1:0]  o_line  [RES_MAX]
);

    typedef struct packed {
        t_res_ctl              ctl;
        logic [CHAR_WIDTH-1:0] val;
        logic [POS_WIDTH-1:0]  start;
        logic [LEN_WIDTH-1:0]  len;
        logic [POS_WIDTH-1:0]  line;
    } t_res;

    localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

    t_lex_state            r_state, n_state;
    t_tok_class            r_cls, n_cls;
    logic [POS_WIDTH-1:0]  r_pos, n_pos;
    logic [POS_WIDTH-1:0]  r_line, n_line;
    logic [POS_WIDTH-1:0]  r_tstart, n_tstart;
    logic [POS_WIDTH-1:0]  r_tline, n_tline;
    logic [LEN_WIDTH-1:0]  r_tlen, n_tlen;
    logic [CHAR_WIDTH-1:0] r_acc, n_acc;

    t_res                  res [RES_MAX];
    logic [31:0]           c;

    function automatic t_res mk_res(input t_res_kind kind, input t_tok_class cls,
                                    input logic [CHAR_WIDTH-1:0] val,
                                    input logic [POS_WIDTH-1:0] start,
                                    input logic [LEN_WIDTH-1:0] len,
                                    input logic [POS_WIDTH-1:0] line);
        t_res r;
        r.ctl.kind = kind;
        r.ctl.cls  = cls;
        r.val      = val;
        r.start    = start;
        r.len      = len;
        r.line     = line;
        return r;
    endfunction

    function automatic logic is_digit(input logic [31:0] x);
        return x >= C_ZERO && x <= C_NINE;
    endfunction

    function automatic logic is_alpha(input logic [31:0] x);
        return (x >= C_UP_A && x <= C_UP_Z) || (x >= C_LO_A && x <= C_LO_Z) || x == C_UNDER;
    endfunction

    function automatic logic is_hex(input logic [31:0] x);
        return is_digit(x) || (x >= C_UP_A && x <= C_UP_F) || (x >= C_LO_A && x <= C_LO_F);
    endfunction

    function automatic logic is_flt(input logic [31:0] x);
        return is_digit(x) || x == C_DOT || x == C_LO_E || x == C_PLUS || x == C_MINUS;
    endfunction

    function automatic logic [LEN_WIDTH-1:0] sat_inc(input logic [LEN_WIDTH-1:0] x);
        return (x == LEN_MAX) ? x : x + 1'b1;
    endfunction

    assign c = 32'(i_ch);

    // next state and results for the character being taken
    always_comb begin
        logic                  again;
        logic [IDX_WIDTH-1:0]  cnt;
        logic [CHAR_WIDTH-1:0] digit;
        n_state  = r_state;
        n_cls    = r_cls;
        n_pos    = r_pos + 1'b1;
        n_line   = r_line;
        n_tstart = r_tstart;
        n_tline  = r_tline;
        n_tlen   = r_tlen;
        n_acc    = r_acc;
        again    = 1'b0;
        cnt      = '0;
        digit    = CHAR_WIDTH'(c - C_ZERO);
        for (int k = 0; k < RES_MAX; k++) begin
            res[k] = mk_res(KD_TOKEN, CL_SYM, '0, '0, '0, '0);
        end

        // token in progress
        unique case (r_state)
            ST_SYM: begin
                if (c == C_COLON || is_alpha(c) || is_digit(c)) begin
                    n_tlen = sat_inc(r_tlen);
                end else begin
                    res[cnt] = mk_res(KD_TOKEN, r_cls, '0, r_tstart, r_tlen, r_tline);
                    cnt = cnt + 1'b1;
                    again = 1'b1;
                end
            end
            ST_HEX: begin
                if (is_hex(c)) begin
                    n_tlen = sat_inc(r_tlen);
                end else begin
                    res[cnt] = mk_res(KD_TOKEN, r_cls, '0, r_tstart, r_tlen, r_tline);
                    cnt = cnt + 1'b1;
                    again = 1'b1;
                end
            end
            ST_INT: begin
                if (is_digit(c)) begin
                    n_tlen = sat_inc(r_tlen);
                end else if (is_flt(c)) begin
                    n_tlen  = sat_inc(r_tlen);
                    n_state = ST_FLT;
                    n_cls   = CL_FLT;
                end else begin
                    res[cnt] = mk_res(KD_TOKEN, r_cls, '0, r_tstart, r_tlen, r_tline);
                    cnt = cnt + 1'b1;
                    again = 1'b1;
                end
            end
            ST_FLT: begin
                if (is_flt(c)) begin
                    n_tlen = sat_inc(r_tlen);
                end else begin
                    res[cnt] = mk_res(KD_TOKEN, r_cls, '0, r_tstart, r_tlen, r_tline);
                    cnt = cnt + 1'b1;
                    again = 1'b1;
                end
            end
            ST_CODE: begin
                if (is_digit(c)) begin
                    n_tlen = sat_inc(r_tlen);
                    n_acc  = (r_acc << 3) + (r_acc << 1) + digit;
                end else begin
                    res[cnt] = mk_res(KD_CHAR, CL_STR, r_acc, r_tstart, '0, r_tline);
                    cnt = cnt + 1'b1;
                    if (c == C_HASH) begin
                        n_tlen = sat_inc(r_tlen);
                        n_acc  = '0;
                    end else if (c == C_QUOTE) begin
                        n_tlen  = sat_inc(r_tlen);
                        n_state = ST_QUOTE;
                    end else begin
                        res[cnt] = mk_res(KD_TOKEN, r_cls, '0, r_tstart, r_tlen, r_tline);
                        cnt = cnt + 1'b1;
                        again = 1'b1;
                    end
                end
            end
            ST_QUOTE: begin
                if (c == C_NUL || c == C_LF || c == C_CR) begin
                    // line break or end inside quotes drops the string
                    res[cnt] = mk_res(KD_ERROR, CL_STR, i_ch, r_tstart, r_tlen, r_tline);
                    cnt = cnt + 1'b1;
                    again = 1'b1;
                end else if (c == C_QUOTE) begin
                    n_tlen  = sat_inc(r_tlen);
                    n_state = ST_AFTERQ;
                end else begin
                    n_tlen = sat_inc(r_tlen);
                    res[cnt] = mk_res(KD_CHAR, CL_STR, i_ch, r_tstart, '0, r_tline);
                    cnt = cnt + 1'b1;
                end
            end
            ST_AFTERQ: begin
                if (c == C_QUOTE) begin
                    // doubled quote gives one quote
                    n_tlen  = sat_inc(r_tlen);
                    n_state = ST_QUOTE;
                    res[cnt] = mk_res(KD_CHAR, CL_STR, i_ch, r_tstart, '0, r_tline);
                    cnt = cnt + 1'b1;
                end else if (c == C_HASH) begin
                    n_tlen  = sat_inc(r_tlen);
                    n_acc   = '0;
                    n_state = ST_CODE;
                end else begin
                    res[cnt] = mk_res(KD_TOKEN, r_cls, '0, r_tstart, r_tlen, r_tline);
                    cnt = cnt + 1'b1;
                    again = 1'b1;
                end
            end
            default: begin
                again = 1'b1;
            end
        endcase

        // character handled between tokens
        if (again) begin
            n_state = ST_IDLE;
            if (c == C_NUL) begin
                res[cnt] = mk_res(KD_TOKEN, CL_END, '0, r_pos, '0, r_line);
                cnt = cnt + 1'b1;
            end else if (c == C_LF) begin
                n_line = r_line + 1'b1;
            end else if (c >= C_FIRST_VIS && c <= C_LAST_VIS) begin
                n_tstart = r_pos;
                n_tline  = r_line;
                n_tlen   = LEN_WIDTH'(1);
                if (is_alpha(c)) begin
                    n_state = ST_SYM;
                    n_cls   = CL_SYM;
                end else if (c == C_HASH) begin
                    n_state = ST_CODE;
                    n_cls   = CL_STR;
                    n_acc   = '0;
                end else if (c == C_QUOTE) begin
                    n_state = ST_QUOTE;
                    n_cls   = CL_STR;
                end else if (c == C_DOLLAR) begin
                    n_state = ST_HEX;
                    n_cls   = CL_INT;
                end else if (c == C_MINUS || is_digit(c)) begin
                    n_state = ST_INT;
                    n_cls   = CL_INT;
                end else begin
                    n_cls = CL_CHAR;
                    res[cnt] = mk_res(KD_TOKEN, CL_CHAR, i_ch, r_pos, LEN_WIDTH'(1), r_line);
                    cnt = cnt + 1'b1;
                end
            end
        end
        o_cnt = cnt;
    end

    // unpack results for the output stage
    always_comb begin
        for (int k = 0; k < RES_MAX; k++) begin
            o_ctl[k]   = res[k].ctl;
            o_val[k]   = res[k].val;
            o_start[k] = res[k].start;
            o_len[k]   = res[k].len;
            o_line[k]  = res[k].line;
        end
    end

    // lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cls    <= CL_SYM;
            r_pos    <= '0;
            r_line   <= POS_WIDTH'(1);
            r_tstart <= '0;
            r_tline  <= POS_WIDTH'(1);
            r_tlen   <= '0;
            r_acc    <= '0;
        end else if (i_take) begin
            r_state  <= n_state;
            r_cls    <= n_cls;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_tstart <= n_tstart;
            r_tline  <= n_tline;
            r_tlen   <= n_tlen;
            r_acc    <= n_acc;
        end
    end

endmodule

[hdl/ftl_out.sv]
// ftl_out: result register and serializer
// holds the results of one character and hands them out one per transfer; uses ftl_pkg
`timescale 1ns / 1ps

module ftl_out
    import ftl_pkg::*;
#(
    parameter int POS_WIDTH  = 32,
    parameter int CHAR_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    output logic                  o_free,
    input  logic [IDX_WIDTH-1:0]  i_cnt,
    input  t_res_ctl              i_ctl   [RES_MAX],
    input  logic [CHAR_WIDTH-1:0] i_val   [RES_MAX],
    input  logic [POS_WIDTH-1:0]  i_start [RES_MAX],
    input  logic [LEN_WIDTH-1:0]  i_len   [RES_MAX],
    input  logic [POS_WIDTH-1:0]  i_line  [RES_MAX],
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_kind,
    output logic [2:0]            o_token_class,
    output logic [CHAR_WIDTH-1:0] o_char_value,
    output logic [POS_WIDTH-1:0]  o_start_pos,
    output logic [LEN_WIDTH-1:0]  o_token_len,
    output logic [POS_WIDTH-1:0]  o_line_no,
    output logic                  o_last
);

    logic [IDX_WIDTH-1:0]  r_cnt;
    logic [IDX_WIDTH-1:0]  r_idx;
    t_res_ctl              r_ctl   [RES_MAX];
    logic [CHAR_WIDTH-1:0] r_val   [RES_MAX];
    logic [POS_WIDTH-1:0]  r_start [RES_MAX];
    logic [LEN_WIDTH-1:0]  r_len   [RES_MAX];
    logic [POS_WIDTH-1:0]  r_line  [RES_MAX];
    logic                  xfer;

    assign o_valid = (r_cnt != '0);
    assign xfer    = o_valid && !i_stall;
    assign o_last  = (r_idx == r_cnt - 1'b1);
    assign o_free  = !o_valid || (xfer && o_last);

    // current result
    assign o_kind        = r_ctl[r_idx].kind;
    assign o_token_class = r_ctl[r_idx].cls;
    assign o_char_value  = r_val[r_idx];
    assign o_start_pos   = r_start[r_idx];
    assign o_token_len   = r_len[r_idx];
    assign o_line_no     = r_line[r_idx];

    // count and index of the group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_idx <= '0;
        end else if (xfer) begin
            if (o_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl   <= i_ctl;
            r_val   <= i_val;
            r_start <= i_start;
            r_len   <= i_len;
            r_line  <= i_line;
        end
    end

endmodule

[hdl/form_text_lexer.sv]
// form_text_lexer: streaming tokenizer for textual form files, top level
// instantiates ftl_in_reg, ftl_core and ftl_out; uses ftl_pkg
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_stall  i_ch
//   result    out        o_valid / i_stall  o_kind, o_token_class, o_char_value,
//                                           o_start_pos, o_token_len, o_line_no, o_last
//
// one character per cycle enters the lexer while the input register is not stalled; a
// character with k results (k is at most three) occupies the result register until all
// k have been transferred, and the next character is taken when the last of them is transferred.
// a character is registered in the input register, then its results in the result register.
// synchronous active-low reset returns the lexer to idle between tokens, position 0, line 1.
// a stalled result stage holds its group and backs up into the input register.
`timescale 1ns / 1ps

module form_text_lexer
    import ftl_pkg::*;
#(
    parameter int POS_WIDTH  = 32,
    parameter int CHAR_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CHAR_WIDTH-1:0] i_ch,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_kind,
    output logic [2:0]            o_token_class,
    output logic [CHAR_WIDTH-1:0] o_char_value,
    output logic [POS_WIDTH-1:0]  o_start_pos,
    output logic [LEN_WIDTH-1:0]  o_token_len,
    output logic [POS_WIDTH-1:0]  o_line_no,
    output logic                  o_last
);

    logic                  w_in_valid;
    logic [CHAR_WIDTH-1:0] w_in_ch;
    logic                  w_free;
    logic                  w_take;
    logic [IDX_WIDTH-1:0]  w_cnt;
    t_res_ctl              w_ctl   [RES_MAX];
    logic [CHAR_WIDTH-1:0] w_val   [RES_MAX];
    logic [POS_WIDTH-1:0]  w_start [RES_MAX];
    logic [LEN_WIDTH-1:0]  w_len   [RES_MAX];
    logic [POS_WIDTH-1:0]  w_line  [RES_MAX];

    // core takes the held character when the result register can load
    assign w_take = w_in_valid && w_free;

    // input register
    ftl_in_reg #(
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_ch    (i_ch),
        .o_valid (w_in_valid),
        .o_ch    (w_in_ch),
        .i_take  (w_take)
    );

    // lexer state and result building
    ftl_core #(
        .POS_WIDTH  (POS_WIDTH),
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_ch    (w_in_ch),
        .o_cnt   (w_cnt),
        .o_ctl   (w_ctl),
        .o_val   (w_val),
        .o_start (w_start),
        .o_len   (w_len),
        .o_line  (w_line)
    );

    // result register and serializer
    ftl_out #(
        .POS_WIDTH  (POS_WIDTH),
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_take),
        .o_free        (w_free),
        .i_cnt         (w_cnt),
        .i_ctl         (w_ctl),
        .i_val         (w_val),
        .i_start       (w_start),
        .i_len         (w_len),
        .i_line        (w_line),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_token_class (o_token_class),
        .o_char_value  (o_char_value),
        .o_start_pos   (o_start_pos),
        .o_token_len   (o_token_len),
        .o_line_no     (o_line_no),
        .o_last        (o_last)
    );

endmodule
